[rtl/bounded_deque_push_pop_dump_defines.svh]
// Assertion macros shared by the deque RTL
`ifndef BOUNDED_DEQUE_PUSH_POP_DUMP_DEFINES_SVH
`define BOUNDED_DEQUE_PUSH_POP_DUMP_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define BDQ_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a trigger is followed by a consequence on the next clock edge
`define BDQ_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
		else $error(msg);
`else
`define BDQ_ASSERT(label, clk, rst_n, prop, msg)
`define BDQ_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg)
`endif

`endif

[rtl/bdq_pkg.sv]
// Shared types and constants for the bounded deque
`timescale 1ns / 1ps
package bdq_pkg;

	localparam int DEPTH_DEFAULT = 32;
	localparam int DATA_W = 32;
	localparam int CMD_W = 2;
	localparam int STATUS_W = 2;
	localparam int CNT_W = 6;

	typedef logic signed [DATA_W-1:0] data_t;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE_BACK = 2'd2;
	localparam logic [CMD_W-1:0] CMD_DUMP = 2'd3;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// Per-cell update selection
	typedef enum logic [1:0] {
		CELL_HOLD       = 2'd0,
		CELL_LOAD       = 2'd1,
		CELL_FROM_LEFT  = 2'd2,
		CELL_FROM_RIGHT = 2'd3
	} cell_op_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		data_t            value;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		data_t               value_res;
		logic                last;
		logic [CNT_W-1:0]    count;
	} rsp_t;

endpackage

[rtl/bounded_deque_push_pop_dump.sv]
// Bounded deque of signed 32-bit values built as a row of shifting cells
//
// Commands are taken when start is high and busy is low. Push back, push
// front and remove back each give a single result: it shows on res with
// res_valid the cycle after the command is taken, and busy stays low, so
// such commands may follow each other on every cycle. A dump of N stored
// elements raises busy and gives N results on consecutive cycles, front
// element first; the first result is registered from the head cell once
// dump_q is set, and the last one shows in the first cycle with busy low
// again. The rate is set by the cell row rotating one element past its
// head per cycle. A dump of an empty deque gives one result the cycle
// after the command and does not raise busy. Results cannot be held off:
// each is valid for exactly one cycle. No clearing pass after reset.
`timescale 1ns / 1ps
`include "bounded_deque_push_pop_dump_defines.svh"
module bounded_deque_push_pop_dump #(
	parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  bdq_pkg::req_t req,
	output logic          busy,
	output logic          res_valid,
	output bdq_pkg::rsp_t res
);
	import bdq_pkg::*;

	localparam int CNT_QW = $clog2(DEPTH + 1);

	logic              accept;
	logic              full;
	logic              empty;
	logic [CNT_QW-1:0] count_q;
	logic [CNT_QW-1:0] count_m1;
	logic [CNT_QW-1:0] count_d;
	logic              dump_q;
	logic [CNT_QW-1:0] dump_idx_q;
	logic              dump_last;
	logic              res_valid_q;
	rsp_t              res_q;
	data_t             load_data;
	data_t             cell_data [DEPTH];

	assign accept = start && !busy;
	assign full = (count_q == CNT_QW'(DEPTH));
	assign empty = (count_q == '0);
	assign count_m1 = count_q - CNT_QW'(1);
	assign dump_last = (dump_idx_q == count_m1);
	assign busy = dump_q;

	// Feed the row: new value on push back, head element on the dump wrap
	assign load_data = dump_q ? cell_data[0] : req.value;

	// Build the cell row and its per-cell control
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		data_t    left_in;
		data_t    right_in;
		cell_op_t op_sel;

		if (i == 0) begin : g_head
			assign left_in = req.value;
		end else begin : g_body_l
			assign left_in = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign right_in = cell_data[0];
		end else begin : g_body_r
			assign right_in = cell_data[i+1];
		end

		always_comb begin
			op_sel = CELL_HOLD;
			if (accept && !full && req.cmd == CMD_PUSH_BACK &&
				count_q == CNT_QW'(i)) begin
				op_sel = CELL_LOAD;
			end else if (accept && !full && req.cmd == CMD_PUSH_FRONT) begin
				op_sel = CELL_FROM_LEFT;
			end else if (dump_q) begin
				op_sel = (count_m1 == CNT_QW'(i)) ? CELL_LOAD : CELL_FROM_RIGHT;
			end
		end

		bdq_cell u_cell (
			.clk        (clk),
			.op         (op_sel),
			.left_data  (left_in),
			.right_data (right_in),
			.load_data  (load_data),
			.data       (cell_data[i])
		);
	end

	// Work out the element count after the request
	always_comb begin
		count_d = count_q;
		unique case (req.cmd)
			CMD_PUSH_BACK, CMD_PUSH_FRONT: if (!full) count_d = count_q + CNT_QW'(1);
			CMD_REMOVE_BACK:               if (!empty) count_d = count_m1;
			CMD_DUMP:                      count_d = count_q;
		endcase
	end

	// Advance count and dump sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			dump_q <= 1'b0;
			dump_idx_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			if (accept) begin
				count_q <= count_d;
				if (req.cmd == CMD_DUMP && !empty) begin
					dump_q <= 1'b1;
					dump_idx_q <= '0;
				end else begin
					res_valid_q <= 1'b1;
				end
			end else if (dump_q) begin
				res_valid_q <= 1'b1;
				dump_idx_q <= dump_idx_q + CNT_QW'(1);
				if (dump_last) begin
					dump_q <= 1'b0;
				end
			end
		end
	end

	// Hold the result payload for its one-cycle strobe
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.value_res <= '0;
			res_q.last <= 1'b1;
			res_q.count <= CNT_W'(count_d);
			unique case (req.cmd)
				CMD_PUSH_BACK, CMD_PUSH_FRONT: res_q.status <= full ? ST_FULL : ST_OK;
				CMD_REMOVE_BACK, CMD_DUMP:     res_q.status <= empty ? ST_EMPTY : ST_OK;
			endcase
		end else if (dump_q) begin
			res_q.status <= ST_OK;
			res_q.value_res <= cell_data[0];
			res_q.last <= dump_last;
			res_q.count <= CNT_W'(count_q);
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

	`BDQ_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_QW'(DEPTH), "count above depth")
	`BDQ_ASSERT_NEXT(a_cmd_result, clk, arst_n, accept && !(req.cmd == CMD_DUMP && !empty), res_valid && res.last, "single result missing")
	`BDQ_ASSERT_NEXT(a_dump_stream, clk, arst_n, dump_q, res_valid && res.status == ST_OK, "dump result missing")
	`BDQ_ASSERT_NEXT(a_dump_end, clk, arst_n, dump_q && dump_last, !busy && res.last, "dump did not end")
	`BDQ_ASSERT_NEXT(a_count_hold, clk, arst_n, !accept, $stable(count_q), "count moved without request")

endmodule

[rtl/bdq_cell.sv]
// One storage cell of the deque row, loading from a neighbor or from the side input
`timescale 1ns / 1ps
module bdq_cell (
	input  logic              clk,
	input  bdq_pkg::cell_op_t op,
	input  bdq_pkg::data_t    left_data,
	input  bdq_pkg::data_t    right_data,
	input  bdq_pkg::data_t    load_data,
	output bdq_pkg::data_t    data
);
	import bdq_pkg::*;

	data_t data_q;

	// Select the next content of the cell
	always_ff @(posedge clk) begin
		case (op)
			CELL_LOAD:       data_q <= load_data;
			CELL_FROM_LEFT:  data_q <= left_data;
			CELL_FROM_RIGHT: data_q <= right_data;
			default:         data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule
